// ----- rtl/ms_adpcm_block_decoder_macros.svh -----
// Assertion macros for the MS ADPCM block decoder.
`ifndef MS_ADPCM_BLOCK_DECODER_MACROS_SVH
`define MS_ADPCM_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define MSA_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("msadpcm check failed");

// Next-cycle implication.
`define MSA_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("msadpcm check failed");

`endif

// ----- rtl/msadpcm_pkg.sv -----
// Shared types, constants and tables of the MS ADPCM block decoder.
package msadpcm_pkg;

    localparam int BA_W            = 13;
    localparam int POS_W           = 13;
    localparam int STEP_W          = 24;
    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int HDR_MONO        = 7;
    localparam int HDR_STEREO      = 14;
    localparam int STEP_FLOOR      = 16;
    localparam int STEP_CAP        = 2796202;
    localparam int PRED_MAX        = 6;
    localparam int QDEPTH          = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ALIGN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 2'd1;

    localparam logic [1:0] OP_PRED = 2'd0;
    localparam logic [1:0] OP_LOW  = 2'd1;
    localparam logic [1:0] OP_WORD = 2'd2;
    localparam logic [1:0] OP_DATA = 2'd3;

    localparam logic [1:0] KIND_STEP  = 2'd0;
    localparam logic [1:0] KIND_NEWER = 2'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic       ch;
        logic       stereo;
        logic       emit_hdr;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic       push;
        logic [1:0] count;
    } q_stat_t;

    function automatic logic signed [10:0] coef_a(input logic [2:0] idx);
        case (idx)
            3'd0:    coef_a = 11'sd256;
            3'd1:    coef_a = 11'sd512;
            3'd2:    coef_a = 11'sd0;
            3'd3:    coef_a = 11'sd192;
            3'd4:    coef_a = 11'sd240;
            3'd5:    coef_a = 11'sd460;
            default: coef_a = 11'sd392;
        endcase
    endfunction

    function automatic logic signed [10:0] coef_b(input logic [2:0] idx);
        case (idx)
            3'd0:    coef_b = 11'sd0;
            3'd1:    coef_b = -11'sd256;
            3'd2:    coef_b = 11'sd0;
            3'd3:    coef_b = 11'sd64;
            3'd4:    coef_b = 11'sd0;
            3'd5:    coef_b = -11'sd208;
            default: coef_b = -11'sd232;
        endcase
    endfunction

    function automatic logic signed [10:0] adapt(input logic [3:0] nib);
        case (nib)
            4'd4, 4'd12: adapt = 11'sd307;
            4'd5, 4'd11: adapt = 11'sd409;
            4'd6, 4'd10: adapt = 11'sd512;
            4'd7, 4'd9:  adapt = 11'sd614;
            4'd8:        adapt = 11'sd768;
            default:     adapt = 11'sd230;
        endcase
    endfunction

endpackage

// ----- rtl/msadpcm_front.sv -----
// Front end: tracks the byte position in the block and classifies each byte.
module msadpcm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [msadpcm_pkg::BA_W-1:0]  block_align,
    input  logic                          stereo_mode,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_end_of_stream,
    input  logic                          q_full,
    output logic                          push,
    output msadpcm_pkg::cmd_t             cmd
);

    logic [msadpcm_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [msadpcm_pkg::POS_W-1:0] lim, hdr;
    logic [msadpcm_pkg::POS_W:0]   pos_inc;
    logic [3:0]                    nch, r;
    logic [2:0]                    word;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    assign lim = (block_align > msadpcm_pkg::BA_W'(msadpcm_pkg::MAX_BLOCK_BYTES))
               ? msadpcm_pkg::POS_W'(msadpcm_pkg::MAX_BLOCK_BYTES) : block_align;
    assign hdr = stereo_mode ? msadpcm_pkg::POS_W'(msadpcm_pkg::HDR_STEREO)
                             : msadpcm_pkg::POS_W'(msadpcm_pkg::HDR_MONO);
    assign pos_inc = {1'b0, pos_reg} + 14'd1;
    assign nch     = {3'b000, stereo_mode} + 4'd1;
    assign r       = pos_reg[3:0] - nch;
    assign word    = r[3:1];

    always_comb begin
        cmd          = '0;
        cmd.stereo   = stereo_mode;
        cmd.data     = s_data_byte;
        cmd.op       = msadpcm_pkg::OP_DATA;
        if (pos_reg < hdr) begin
            cmd.emit_hdr = (pos_reg == hdr - 13'd1);
            if (pos_reg < {9'd0, nch}) begin
                cmd.op = msadpcm_pkg::OP_PRED;
                cmd.ch = pos_reg[0];
                if (s_data_byte > 8'(msadpcm_pkg::PRED_MAX)) begin
                    cmd.data = 8'(msadpcm_pkg::PRED_MAX);
                end
            end else begin
                cmd.op   = r[0] ? msadpcm_pkg::OP_WORD : msadpcm_pkg::OP_LOW;
                cmd.kind = stereo_mode ? word[2:1] : word[1:0];
                cmd.ch   = stereo_mode ? word[0] : 1'b0;
            end
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (push) begin
            if (s_end_of_stream || pos_inc >= {1'b0, lim}) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc[msadpcm_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- rtl/msadpcm_queue.sv -----
// Short command queue between the front end and the decode engine.
module msadpcm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  msadpcm_pkg::cmd_t  wr_data,
    input  logic               pop,
    output msadpcm_pkg::cmd_t  rd_data,
    output msadpcm_pkg::q_stat_t stat
);

    localparam int PTR_W = $clog2(msadpcm_pkg::QDEPTH);

    msadpcm_pkg::cmd_t mem [msadpcm_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == 2'(msadpcm_pkg::QDEPTH));
    assign stat.empty = (count_reg == 2'd0);
    assign stat.push  = push;
    assign rd_data    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/msadpcm_back.sv -----
// Decode engine: header state, nibble expansion on one shared multiplier, output stage.
module msadpcm_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    input  msadpcm_pkg::cmd_t        q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_pcm_sample,
    output logic                     m_channel_index,
    output logic                     m_last_of_run
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_M3   = 3'd4;
    localparam logic [2:0] ST_M4   = 3'd5;
    localparam logic [2:0] ST_M5   = 3'd6;

    localparam int SW = msadpcm_pkg::STEP_W;

    logic [2:0]              state_reg, state_next;
    msadpcm_pkg::cmd_t       cmd_reg, cmd_next;
    logic                    nib_sel_reg, nib_sel_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [2:0]              pred_reg [2], pred_next [2];
    logic signed [SW-1:0]    step_reg [2], step_next [2];
    logic signed [15:0]      newer_reg [2], newer_next [2];
    logic signed [15:0]      older_reg [2], older_next [2];
    logic [7:0]              low_reg, low_next;
    logic signed [35:0]      acc_reg, acc_next;
    logic signed [17:0]      quot_reg, quot_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [15:0]      pcm_reg, pcm_next;
    logic                    ch_reg, ch_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic                    cur_ch;
    logic [3:0]              nib;
    logic signed [SW-1:0]    mul_a;
    logic signed [10:0]      mul_b;
    logic signed [34:0]      prod;
    logic signed [35:0]      shr, qt, sum, d;
    logic signed [15:0]      word_v;

    assign out_free        = !m_valid_reg || m_ready;
    assign cur_ch          = nib_sel_reg ? cmd_reg.stereo : 1'b0;
    assign nib             = nib_sel_reg ? cmd_reg.data[3:0] : cmd_reg.data[7:4];
    assign prod            = mul_a * mul_b;
    assign shr             = acc_reg >>> 8;
    assign qt              = shr + ((acc_reg[35] && (|acc_reg[7:0])) ? 36'sd1 : 36'sd0);
    assign sum             = {{18{quot_reg[17]}}, quot_reg} + acc_reg;
    assign d               = shr;
    assign word_v          = {q_data.data, low_reg};
    assign q_pop           = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid         = m_valid_reg;
    assign m_pcm_sample    = pcm_reg;
    assign m_channel_index = ch_reg;
    assign m_last_of_run   = last_reg;

    // shared multiplier operand select
    always_comb begin
        mul_a = step_reg[cur_ch];
        mul_b = msadpcm_pkg::adapt(nib);
        case (state_reg)
            ST_M1: begin
                mul_a = {{(SW-16){newer_reg[cur_ch][15]}}, newer_reg[cur_ch]};
                mul_b = msadpcm_pkg::coef_a(pred_reg[cur_ch]);
            end
            ST_M2: begin
                mul_a = {{(SW-16){older_reg[cur_ch][15]}}, older_reg[cur_ch]};
                mul_b = msadpcm_pkg::coef_b(pred_reg[cur_ch]);
            end
            ST_M3: begin
                mul_b = {{7{nib[3]}}, nib};
            end
            default: begin
                mul_b = msadpcm_pkg::adapt(nib);
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        nib_sel_next = nib_sel_reg;
        cnt_next     = cnt_reg;
        pred_next    = pred_reg;
        step_next    = step_reg;
        newer_next   = newer_reg;
        older_next   = older_reg;
        low_next     = low_reg;
        acc_next     = acc_reg;
        quot_next    = quot_reg;
        pcm_next     = pcm_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    cmd_next     = q_data;
                    nib_sel_next = 1'b0;
                    cnt_next     = 2'd0;
                    case (q_data.op)
                        msadpcm_pkg::OP_PRED: begin
                            pred_next[q_data.ch] = q_data.data[2:0];
                        end
                        msadpcm_pkg::OP_LOW: begin
                            low_next = q_data.data;
                        end
                        msadpcm_pkg::OP_WORD: begin
                            if (q_data.kind == msadpcm_pkg::KIND_STEP) begin
                                step_next[q_data.ch] = {{(SW-16){word_v[15]}}, word_v};
                            end else if (q_data.kind == msadpcm_pkg::KIND_NEWER) begin
                                newer_next[q_data.ch] = word_v;
                            end else begin
                                older_next[q_data.ch] = word_v;
                            end
                        end
                        default: begin
                            state_next = ST_M1;
                        end
                    endcase
                    if (q_data.emit_hdr) begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (cmd_reg.stereo) begin
                        ch_next   = cnt_reg[0];
                        pcm_next  = cnt_reg[1] ? newer_reg[cnt_reg[0]] : older_reg[cnt_reg[0]];
                        last_next = (cnt_reg == 2'd3);
                    end else begin
                        ch_next   = 1'b0;
                        pcm_next  = (cnt_reg == 2'd0) ? older_reg[0] : newer_reg[0];
                        last_next = (cnt_reg == 2'd1);
                    end
                    cnt_next = cnt_reg + 2'd1;
                    if (last_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_M1: begin
                acc_next   = {prod[34], prod};
                state_next = ST_M2;
            end
            ST_M2: begin
                acc_next   = acc_reg + {prod[34], prod};
                state_next = ST_M3;
            end
            ST_M3: begin
                // prediction / 256, truncated toward zero
                quot_next  = qt[17:0];
                acc_next   = {prod[34], prod};
                state_next = ST_M4;
            end
            ST_M4: begin
                if (out_free) begin
                    if (sum < -36'sd32768) begin
                        pcm_next = 16'sh8000;
                    end else if (sum > 36'sd32767) begin
                        pcm_next = 16'sh7fff;
                    end else begin
                        pcm_next = sum[15:0];
                    end
                    older_next[cur_ch] = newer_reg[cur_ch];
                    newer_next[cur_ch] = pcm_next;
                    ch_next      = cur_ch;
                    last_next    = nib_sel_reg;
                    m_valid_next = 1'b1;
                    acc_next     = {prod[34], prod};
                    state_next   = ST_M5;
                end
            end
            ST_M5: begin
                if (d < 36'sd16) begin
                    step_next[cur_ch] = SW'(msadpcm_pkg::STEP_FLOOR);
                end else if (d > 36'sd2796202) begin
                    step_next[cur_ch] = SW'(msadpcm_pkg::STEP_CAP);
                end else begin
                    step_next[cur_ch] = d[SW-1:0];
                end
                if (nib_sel_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    nib_sel_next = 1'b1;
                    state_next   = ST_M1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        acc_reg   <= acc_next;
        quot_reg  <= quot_next;
        pcm_reg   <= pcm_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        cnt_reg   <= cnt_next;
        nib_sel_reg <= nib_sel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            low_reg     <= '0;
            for (int i = 0; i < 2; i++) begin
                pred_reg[i]  <= '0;
                step_reg[i]  <= '0;
                newer_reg[i] <= '0;
                older_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            low_reg     <= low_next;
            for (int i = 0; i < 2; i++) begin
                pred_reg[i]  <= pred_next[i];
                step_reg[i]  <= step_next[i];
                newer_reg[i] <= newer_next[i];
                older_reg[i] <= older_next[i];
            end
        end
    end

endmodule

// ----- rtl/ms_adpcm_block_decoder.sv -----
// MS ADPCM block decoder top level: config registers, front end, queue, decode engine.
// Header byte: the byte that completes the header emits 2 (mono) or 4 (stereo) samples,
// one per cycle while the output is not stalled.
// Data byte: decoded by the five-step sequence per nibble on the one shared multiplier;
// high nibble first, then low nibble; no new command is taken until both are done.
// Reset (aresetn low, synchronous): position to block start, decoder state to zero,
// block_align to 512, stereo_mode to 0, queue and output emptied.
module ms_adpcm_block_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msadpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msadpcm_pkg::BA_W-1:0]       cfg_data,
    // stream bytes in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_end_of_stream,
    // PCM samples out
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [15:0]                 m_pcm_sample,
    output logic                               m_channel_index,
    output logic                               m_last_of_run
);

`include "ms_adpcm_block_decoder_macros.svh"

    logic [msadpcm_pkg::BA_W-1:0] block_align_reg, block_align_next;
    logic                         stereo_mode_reg, stereo_mode_next;

    msadpcm_pkg::cmd_t    front_cmd, q_cmd;
    msadpcm_pkg::q_stat_t q_stat;
    logic                 q_push, q_pop;

    // Config port never stalls; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        block_align_next = block_align_reg;
        stereo_mode_next = stereo_mode_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                msadpcm_pkg::REG_BLOCK_ALIGN: block_align_next = cfg_data;
                msadpcm_pkg::REG_STEREO_MODE: stereo_mode_next = cfg_data[0];
                default: begin
                    block_align_next = block_align_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_align_reg <= 13'd512;
            stereo_mode_reg <= 1'b0;
        end else begin
            block_align_reg <= block_align_next;
            stereo_mode_reg <= stereo_mode_next;
        end
    end

    // Front end: byte position and classification; one command per byte transfer.
    msadpcm_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .block_align     (block_align_reg),
        .stereo_mode     (stereo_mode_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .q_full          (q_stat.full),
        .push            (q_push),
        .cmd             (front_cmd)
    );

    // Two-entry command queue decouples byte intake from sample decode.
    msadpcm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (front_cmd),
        .pop     (q_pop),
        .rd_data (q_cmd),
        .stat    (q_stat)
    );

    // Decode engine with registered output stage.
    msadpcm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_stat.empty),
        .q_data          (q_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pcm_sample    (m_pcm_sample),
        .m_channel_index (m_channel_index),
        .m_last_of_run   (m_last_of_run)
    );

    // queue occupancy bounded by its depth
    `MSA_CHK_NOW(a_q_depth, 1'b1, q_stat.count <= 2'(msadpcm_pkg::QDEPTH))
    // front never pushes into a full queue
    `MSA_CHK_NOW(a_q_no_overflow, q_stat.push, !q_stat.full)
    // mono output always on channel 0
    `MSA_CHK_NOW(a_mono_chan, m_valid && !stereo_mode_reg, !m_channel_index)

endmodule
